/* design/ubxfr_pkg.sv */
`default_nettype none

package ubxfr_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned OFFSET_W  = 7;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = CFG_IDX_W'(1);

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd181;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd98;

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_BODY,
        PH_CK_A,
        PH_CK_B
    } phase_t;

endpackage

`default_nettype wire

/* design/ubx_frame_receiver.sv */
// channel  dir  handshake          payload
// s_       in   s_valid/s_ready    s_rx_byte
// m_       out  m_valid/m_ready    m_body_valid, m_body_offset, m_body_byte,
//                                  m_frame_done, m_frame_good
// cfg_     in   cfg_wr_en          cfg_index, cfg_data
//
// One beat per cycle while m_ready drains results; each accepted byte yields one result beat in the next cycle.
// Rate is set by the single result register: a byte is taken whenever it is
// empty or being drained in the same cycle.
// Synchronous active-low reset: hunting first sync byte, sums cleared,
// sync bytes back to 181 and 98.
// A stalled m_ready holds the result and blocks s_ready until it is taken.
`default_nettype none

module ubx_frame_receiver #(
    parameter int unsigned FRAME_BYTES = 96
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    input  wire logic                                 cfg_wr_en,
    input  wire logic [ubxfr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ubxfr_pkg::BYTE_W-1:0]         cfg_data,

    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [ubxfr_pkg::BYTE_W-1:0]         s_rx_byte,

    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_body_valid,
    output logic [ubxfr_pkg::OFFSET_W-1:0]            m_body_offset,
    output logic [ubxfr_pkg::BYTE_W-1:0]              m_body_byte,
    output logic                                      m_frame_done,
    output logic                                      m_frame_good
);

    localparam int unsigned OFS_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int unsigned EXT_W = (OFS_W > ubxfr_pkg::OFFSET_W) ? OFS_W
                                                                  : ubxfr_pkg::OFFSET_W;
    localparam logic [OFS_W-1:0] OFS_LAST = OFS_W'(FRAME_BYTES - 1);

    ubxfr_pkg::phase_t phase_reg, phase_next;
    logic [OFS_W-1:0]                 ofs_reg, ofs_next;
    logic [ubxfr_pkg::BYTE_W-1:0]     sum_a_reg, sum_a_next;
    logic [ubxfr_pkg::BYTE_W-1:0]     sum_b_reg, sum_b_next;
    logic [ubxfr_pkg::BYTE_W-1:0]     sync_first_reg, sync_second_reg;

    logic                             m_valid_reg;
    logic                             body_valid_reg, body_valid_next;
    logic [ubxfr_pkg::OFFSET_W-1:0]   body_offset_reg, body_offset_next;
    logic [ubxfr_pkg::BYTE_W-1:0]     body_byte_reg, body_byte_next;
    logic                             frame_done_reg, frame_done_next;
    logic                             frame_good_reg, frame_good_next;

    logic                             accept;
    logic [EXT_W-1:0]                 ofs_ext;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign ofs_ext = EXT_W'(ofs_reg);

    // next state
    always_comb begin
        phase_next = phase_reg;
        ofs_next   = ofs_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        case (phase_reg)
            ubxfr_pkg::PH_SYNC1: begin
                if (s_rx_byte == sync_first_reg) begin
                    phase_next = ubxfr_pkg::PH_SYNC2;
                end
            end
            ubxfr_pkg::PH_SYNC2: begin
                if (s_rx_byte == sync_second_reg) begin
                    phase_next = ubxfr_pkg::PH_BODY;
                    ofs_next   = '0;
                    sum_a_next = '0;
                    sum_b_next = '0;
                end else begin
                    phase_next = ubxfr_pkg::PH_SYNC1;
                end
            end
            ubxfr_pkg::PH_BODY: begin
                sum_a_next = sum_a_reg + s_rx_byte;
                sum_b_next = sum_b_reg + sum_a_next;
                ofs_next   = ofs_reg + OFS_W'(1);
                if (ofs_reg == OFS_LAST) begin
                    phase_next = ubxfr_pkg::PH_CK_A;
                end
            end
            ubxfr_pkg::PH_CK_A: begin
                phase_next = (s_rx_byte == sum_a_reg) ? ubxfr_pkg::PH_CK_B
                                                      : ubxfr_pkg::PH_SYNC1;
            end
            ubxfr_pkg::PH_CK_B: begin
                phase_next = ubxfr_pkg::PH_SYNC1;
            end
            default: begin
                phase_next = ubxfr_pkg::PH_SYNC1;
            end
        endcase
    end

    // result beat
    always_comb begin
        body_valid_next  = 1'b0;
        body_offset_next = '0;
        body_byte_next   = '0;
        frame_done_next  = 1'b0;
        frame_good_next  = 1'b0;
        case (phase_reg)
            ubxfr_pkg::PH_BODY: begin
                body_valid_next  = 1'b1;
                body_offset_next = ofs_ext[ubxfr_pkg::OFFSET_W-1:0];
                body_byte_next   = s_rx_byte;
            end
            ubxfr_pkg::PH_CK_A: begin
                frame_done_next = (s_rx_byte != sum_a_reg);
            end
            ubxfr_pkg::PH_CK_B: begin
                frame_done_next = 1'b1;
                frame_good_next = (s_rx_byte == sum_b_reg);
            end
            default: begin
                frame_done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= ubxfr_pkg::PH_SYNC1;
            ofs_reg         <= '0;
            sum_a_reg       <= '0;
            sum_b_reg       <= '0;
            sync_first_reg  <= ubxfr_pkg::SYNC_FIRST_RST;
            sync_second_reg <= ubxfr_pkg::SYNC_SECOND_RST;
            m_valid_reg     <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                ofs_reg   <= ofs_next;
                sum_a_reg <= sum_a_next;
                sum_b_reg <= sum_b_next;
            end
            if (cfg_wr_en && cfg_index == ubxfr_pkg::CFG_SYNC_FIRST) begin
                sync_first_reg <= cfg_data;
            end
            if (cfg_wr_en && cfg_index == ubxfr_pkg::CFG_SYNC_SECOND) begin
                sync_second_reg <= cfg_data;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            body_valid_reg  <= body_valid_next;
            body_offset_reg <= body_offset_next;
            body_byte_reg   <= body_byte_next;
            frame_done_reg  <= frame_done_next;
            frame_good_reg  <= frame_good_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_body_valid  = body_valid_reg;
    assign m_body_offset = body_offset_reg;
    assign m_body_byte   = body_byte_reg;
    assign m_frame_done  = frame_done_reg;
    assign m_frame_good  = frame_good_reg;

`ifndef SYNTH
    a_body_xor_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(body_valid_reg && frame_done_reg))
        else $error("body beat flagged as frame end");

    a_good_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && frame_good_reg |-> frame_done_reg)
        else $error("frame_good without frame_done");

    a_ckb_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && phase_reg == ubxfr_pkg::PH_CK_B
        |=> m_valid_reg && frame_done_reg && phase_reg == ubxfr_pkg::PH_SYNC1)
        else $error("checksum B byte did not close the frame");

    a_body_last: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && phase_reg == ubxfr_pkg::PH_BODY && ofs_reg == OFS_LAST
        |=> phase_reg == ubxfr_pkg::PH_CK_A)
        else $error("last body byte did not move to checksum A");
`endif

endmodule

`default_nettype wire
